// ----- sv/bme_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bme_pkg
// types and constants of the 8x8 block mean and energy statistic
// ----------------------------------------------------------------------------
package bme_pkg;

    localparam int PIX_W       = 8;
    localparam int PIX_PER_ROW = 8;
    localparam int ROW_W       = PIX_W * PIX_PER_ROW;
    localparam int TOTAL_W     = 22;
    localparam int CONTRIB_W   = 20;
    localparam int OUT_W       = 32;
    localparam int ROW_CNT_W   = 3;
    localparam int MODE_W      = 2;
    localparam int SHIFT_W     = 4;

    localparam logic [ROW_CNT_W-1:0] LAST_ROW = 3'd7;

    // statistic select codes
    localparam logic [MODE_W-1:0] MODE_FULL_SQ = 2'd0;
    localparam logic [MODE_W-1:0] MODE_EVEN_SQ = 2'd1;
    localparam logic [MODE_W-1:0] MODE_EVEN_SUM = 2'd2;

    localparam logic [SHIFT_W-1:0] SHIFT_FULL_SQ  = 4'd10;
    localparam logic [SHIFT_W-1:0] SHIFT_EVEN_SQ  = 4'd11;
    localparam logic [SHIFT_W-1:0] SHIFT_EVEN_SUM = 4'd3;

    typedef logic [ROW_W-1:0]     t_row;
    typedef logic [TOTAL_W-1:0]   t_total;
    typedef logic [CONTRIB_W-1:0] t_contrib;
    typedef logic [OUT_W-1:0]     t_value;
    typedef logic [MODE_W-1:0]    t_mode;

    // per-row control captured with the item
    typedef struct packed {
        logic                 use_row;  // row adds to the total
        logic                 squares;  // add squares, else plain sum
        logic                 last;     // eighth row of the block
        logic [SHIFT_W-1:0]   shift;    // final scale for the last row
    } t_row_ctl;

endpackage

// ----- sv/block_mean_and_energy_8x8_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_mean_and_energy_8x8_top
// streaming 8x8 block sum of squares / pixel sum statistic
// ----------------------------------------------------------------------------
// usage
//   input channel: one item per pixel row (eight 8-bit pixels, pixel 0 in
//   bits 7:0), rows 0 to 7 of a block in order, valid/ready handshake
//   config channel: 2-bit stat_mode, always ready, write only while idle
//     0 full squares << 10, 1 even-row squares << 11, 2 even-row sum << 3,
//     code 3 acts as mode 0
//   output channel: one 32-bit item per block, after the eighth row
// timing
//   one row per cycle unless the output stalls; the result is registered
//   once the eighth row passes the input register and is accumulated into
//   the result register. the rate is set by the combinational reduction:
//   eight 8x8 squares and an adder tree feeding the 22-bit accumulator
// reset
//   synchronous, active low: mode 0, row count and total cleared, no item
// stall
//   only the last row of a block needs the output register; while a result
//   waits, rows 0 to 6 of the next block keep flowing, the last row holds
//   in the input register and in_ready drops until the result is taken
// ----------------------------------------------------------------------------
module block_mean_and_energy_8x8_top (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [1:0]            i_cfg_stat_mode,
    // row input
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [63:0]           i_row_pixels,
    // block result
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [31:0]           o_block_value
);
    import bme_pkg::*;

    // mode register
    t_mode                  r_mode;
    // acceptance-side row counter
    logic [ROW_CNT_W-1:0]   r_row_cnt;
    logic [ROW_CNT_W-1:0]   n_row_cnt;
    // input register stage
    logic                   r_s1_valid;
    t_row                   r_s1_row;
    t_row_ctl               r_s1_ctl;
    t_row_ctl               n_s1_ctl;
    // accumulator and result register
    t_total                 r_total;
    t_total                 n_total;
    logic                   r_out_valid;
    t_value                 r_out_value;
    t_value                 n_out_value;

    logic                   in_acc;
    logic                   out_free;
    logic                   s1_move;
    logic                   row_even;
    t_contrib               row_sq;
    t_contrib               row_sum;
    t_contrib               contrib;
    t_total                 total_sum;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_FULL_SQ;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_mode <= i_cfg_stat_mode;
        end
    end

    // the output slot is free now or is emptied at this edge
    assign out_free = !r_out_valid || i_out_ready;
    // only a last row needs the output slot
    assign s1_move  = r_s1_valid && (!r_s1_ctl.last || out_free);
    assign o_in_ready = !r_s1_valid || s1_move;
    assign in_acc   = i_in_valid && o_in_ready;

    // decode the mode for the incoming row
    assign row_even = !r_row_cnt[0];
    always_comb begin
        n_s1_ctl.last = (r_row_cnt == LAST_ROW);
        case (r_mode)
            MODE_EVEN_SQ: begin
                n_s1_ctl.use_row = row_even;
                n_s1_ctl.squares = 1'b1;
                n_s1_ctl.shift   = SHIFT_EVEN_SQ;
            end
            MODE_EVEN_SUM: begin
                n_s1_ctl.use_row = row_even;
                n_s1_ctl.squares = 1'b0;
                n_s1_ctl.shift   = SHIFT_EVEN_SUM;
            end
            default: begin
                // full squares, unused code too
                n_s1_ctl.use_row = 1'b1;
                n_s1_ctl.squares = 1'b1;
                n_s1_ctl.shift   = SHIFT_FULL_SQ;
            end
        endcase
    end

    // counter wraps naturally from the last row to row 0
    assign n_row_cnt = r_row_cnt + ROW_CNT_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_cnt  <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_row_cnt <= n_row_cnt;
            end
            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_row <= i_row_pixels;
            r_s1_ctl <= n_s1_ctl;
        end
    end

    // row reduction: eight independent squares and pixels, summed
    always_comb begin
        logic [PIX_W-1:0]     pix;
        logic [2*PIX_W-1:0]   sq;
        row_sq  = '0;
        row_sum = '0;
        for (int i = 0; i < PIX_PER_ROW; i++) begin
            pix     = r_s1_row[i*PIX_W +: PIX_W];
            sq      = (2*PIX_W)'(pix) * (2*PIX_W)'(pix);
            row_sq  = row_sq + CONTRIB_W'(sq);
            row_sum = row_sum + CONTRIB_W'(pix);
        end
    end

    always_comb begin
        if (!r_s1_ctl.use_row) begin
            contrib = '0;
        end else if (r_s1_ctl.squares) begin
            contrib = row_sq;
        end else begin
            contrib = row_sum;
        end
    end

    assign total_sum   = r_total + TOTAL_W'(contrib);
    // scale and keep the low 32 bits
    assign n_out_value = OUT_W'(total_sum) << r_s1_ctl.shift;
    assign n_total     = r_s1_ctl.last ? '0 : total_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_move) begin
                r_total <= n_total;
            end
            if (s1_move && r_s1_ctl.last) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move && r_s1_ctl.last) begin
            r_out_value <= n_out_value;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_block_value = r_out_value;

    // row counter returns to row 0 after the last row of a block
    a_cnt_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && r_row_cnt == LAST_ROW) |=> (r_row_cnt == '0))
        else $error("row counter did not wrap after last row");

    // a result only ever comes from a last row leaving the input stage
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_s1_valid && r_s1_ctl.last))
        else $error("result without a last row");

    // accumulator is cleared once a block completes
    a_total_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_move && r_s1_ctl.last) |=> (r_total == '0))
        else $error("accumulator not cleared after block");

    // a waiting result is never overwritten by the next block
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !(s1_move && r_s1_ctl.last))
        else $error("result overwritten while stalled");

endmodule
